>>> sv/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;
	// cordic datapath width: |x|,|y| up to about 2^32 * 1.65 gain
	localparam int DW = 36;
	localparam int ZW = 34;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;
	localparam int PIPE_LAT = CORDIC_STEPS + 1;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [14:0] HALF_PI_Q13 = 15'sd12868;
	// square root: 29 result bits from a 58 bit radicand, 4 bits a stage
	localparam int SQ_BITS = 29;
	localparam int SQ_PER_STAGE = 4;
	localparam int SQ_STAGES = (SQ_BITS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [14:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] roll_angle;
		logic gimbal_clamp;
	} euler_t;

	// front to back: products reduced to atan2 operand pairs
	typedef struct packed {
		logic signed [DW-1:0] sr;
		logic signed [DW-1:0] cr;
		logic signed [DW-1:0] sy;
		logic signed [DW-1:0] cy;
		logic signed [DW-1:0] sp;
		logic [57:0] rem;
		logic clamp;
	} front_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] t;
		case (i)
			0: t = 34'sd843314856; 1: t = 34'sd497837829;
			2: t = 34'sd263043836; 3: t = 34'sd133525158;
			4: t = 34'sd67021686; 5: t = 34'sd33543515;
			6: t = 34'sd16775850; 7: t = 34'sd8388437;
			8: t = 34'sd4194282; 9: t = 34'sd2097149;
			10: t = 34'sd1048575; 11: t = 34'sd524287;
			12: t = 34'sd262143; 13: t = 34'sd131071;
			14: t = 34'sd65535; 15: t = 34'sd32767;
			16: t = 34'sd16383; 17: t = 34'sd8191;
			18: t = 34'sd4095; 19: t = 34'sd2047;
			20: t = 34'sd1023; 21: t = 34'sd511;
			22: t = 34'sd255; default: t = 34'sd127;
		endcase
		return t;
	endfunction
endpackage

>>> sv/qte_stream_if.sv
`timescale 1ns / 1ps
interface qte_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> sv/qte_front.sv
`timescale 1ns / 1ps
module qte_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input qte_pkg::quat_t in_data,
	input logic enable,
	output logic out_valid,
	output qte_pkg::front_t out_data
);
	import qte_pkg::*;

	logic v_s1;
	logic v_s2;
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, zz_s1, wy_s1, zx_s1, wz_s1, xy_s1;
	front_t f_s2;
	logic signed [DW-1:0] sp_c;
	logic [57:0] sq_c;

	// stage 1: products
	always_ff @(posedge clk) begin
		if (enable) begin
			wx_s1 <= in_data.w * in_data.x;
			yz_s1 <= in_data.y * in_data.z;
			xx_s1 <= in_data.x * in_data.x;
			yy_s1 <= in_data.y * in_data.y;
			zz_s1 <= in_data.z * in_data.z;
			wy_s1 <= in_data.w * in_data.y;
			zx_s1 <= in_data.z * in_data.x;
			wz_s1 <= in_data.w * in_data.z;
			xy_s1 <= in_data.x * in_data.y;
		end
	end

	assign sp_c = (DW'(wy_s1) - DW'(zx_s1)) <<< 1;
	// square only matters below saturation, where the sine fits in 29 signed bits
	assign sq_c = 58'($signed(sp_c[28:0]) * $signed(sp_c[28:0]));

	// stage 2: sums and pitch classification
	always_ff @(posedge clk) begin
		if (enable) begin
			f_s2.sr <= (DW'(wx_s1) + DW'(yz_s1)) <<< 1;
			f_s2.cr <= (DW'(1) <<< 28) - ((DW'(xx_s1) + DW'(yy_s1)) <<< 1);
			f_s2.sy <= (DW'(wz_s1) + DW'(xy_s1)) <<< 1;
			f_s2.cy <= (DW'(1) <<< 28) - ((DW'(yy_s1) + DW'(zz_s1)) <<< 1);
			f_s2.sp <= sp_c;
			f_s2.clamp <= (sp_c >= (DW'(1) <<< 28)) || (sp_c <= -(DW'(1) <<< 28));
			f_s2.rem <= (58'(1) << 56) - sq_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (enable) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data = f_s2;
endmodule

>>> sv/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic (
	input logic clk,
	input logic enable,
	input logic signed [qte_pkg::DW-1:0] y_in,
	input logic signed [qte_pkg::DW-1:0] x_in,
	output logic signed [qte_pkg::ZW-1:0] z_out
);
	import qte_pkg::*;

	logic signed [DW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [DW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];

	// stage 0: quadrant fold
	always_ff @(posedge clk) begin
		if (enable) begin
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	// one rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (enable) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_entry(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_entry(i);
				end
			end
		end
	end

	// zero vector gives zero, which the fold and rotations would not
	logic zero_q [CORDIC_STEPS+1];
	always_ff @(posedge clk) begin
		if (enable) zero_q[0] <= (x_in == 0) && (y_in == 0);
	end
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_zero
		always_ff @(posedge clk) begin
			if (enable) zero_q[i+1] <= zero_q[i];
		end
	end

	assign z_out = zero_q[CORDIC_STEPS] ? '0 : z_s[CORDIC_STEPS];
endmodule

>>> sv/qte_sqrt.sv
`timescale 1ns / 1ps
module qte_sqrt (
	input logic clk,
	input logic enable,
	input logic [57:0] rad_in,
	output logic [28:0] root_out
);
	import qte_pkg::*;

	// restoring root, a few result bits a stage, msb first
	logic [57:0] r_s [SQ_STAGES+1];
	logic [28:0] q_s [SQ_STAGES+1];
	logic [59:0] a_s [SQ_STAGES+1];

	assign r_s[0] = rad_in;
	assign q_s[0] = '0;
	assign a_s[0] = '0;

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_st
		logic [57:0] r_c;
		logic [28:0] q_c;
		logic [59:0] a_c;
		always_comb begin
			logic [59:0] t;
			int b;
			r_c = r_s[g];
			q_c = q_s[g];
			a_c = a_s[g];
			for (int k = 0; k < SQ_PER_STAGE; k++) begin
				b = SQ_BITS - 1 - g * SQ_PER_STAGE - k;
				if (b >= 0) begin
					a_c = {a_c[57:0], r_c[57:56]};
					r_c = {r_c[55:0], 2'b00};
					t = {q_c, 2'b01};
					if (a_c >= t) begin
						a_c = a_c - t;
						q_c = {q_c[27:0], 1'b1};
					end else begin
						q_c = {q_c[27:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (enable) begin
				r_s[g+1] <= r_c;
				q_s[g+1] <= q_c;
				a_s[g+1] <= a_c;
			end
		end
	end

	assign root_out = q_s[SQ_STAGES];
endmodule

>>> sv/qte_back.sv
`timescale 1ns / 1ps
module qte_back (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input qte_pkg::front_t in_data,
	input logic enable,
	output logic out_valid,
	output qte_pkg::euler_t out_data
);
	import qte_pkg::*;

	localparam int LAT = SQ_STAGES + PIPE_LAT + 1;

	logic signed [DW-1:0] sr_d [SQ_STAGES+1];
	logic signed [DW-1:0] cr_d [SQ_STAGES+1];
	logic signed [DW-1:0] sy_d [SQ_STAGES+1];
	logic signed [DW-1:0] cy_d [SQ_STAGES+1];
	logic signed [DW-1:0] sp_d [SQ_STAGES+1];
	logic clamp_d [LAT];
	logic sign_d [LAT];
	logic v_d [LAT];
	logic [28:0] root;
	logic signed [ZW-1:0] zr, zy, zp;
	euler_t res_q;

	assign sr_d[0] = in_data.sr;
	assign cr_d[0] = in_data.cr;
	assign sy_d[0] = in_data.sy;
	assign cy_d[0] = in_data.cy;
	assign sp_d[0] = in_data.sp;

	// delay the atan2 operands to line up with the root
	for (genvar i = 0; i < SQ_STAGES; i++) begin : g_al
		always_ff @(posedge clk) begin
			if (enable) begin
				sr_d[i+1] <= sr_d[i];
				cr_d[i+1] <= cr_d[i];
				sy_d[i+1] <= sy_d[i];
				cy_d[i+1] <= cy_d[i];
				sp_d[i+1] <= sp_d[i];
			end
		end
	end

	qte_sqrt u_sqrt (.clk, .enable, .rad_in(in_data.rem), .root_out(root));

	qte_cordic u_roll (.clk, .enable, .y_in(sr_d[SQ_STAGES]), .x_in(cr_d[SQ_STAGES]),
		.z_out(zr));
	qte_cordic u_yaw (.clk, .enable, .y_in(sy_d[SQ_STAGES]), .x_in(cy_d[SQ_STAGES]),
		.z_out(zy));
	qte_cordic u_pitch (.clk, .enable, .y_in(sp_d[SQ_STAGES]), .x_in(DW'(root)),
		.z_out(zp));

	always_ff @(posedge clk) begin
		if (enable) begin
			clamp_d[0] <= in_data.clamp;
			sign_d[0] <= in_data.sp > 0;
		end
	end
	for (genvar i = 0; i < LAT - 1; i++) begin : g_fl
		always_ff @(posedge clk) begin
			if (enable) begin
				clamp_d[i+1] <= clamp_d[i];
				sign_d[i+1] <= sign_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) v_d[i] <= 1'b0;
		end else if (enable) begin
			v_d[0] <= in_valid;
			for (int i = 1; i < LAT; i++) v_d[i] <= v_d[i-1];
		end
	end

	// round to Q3.13 and saturate
	function automatic logic signed [ZW-18:0] rnd(input logic signed [ZW-1:0] a);
		logic signed [ZW-1:0] t;
		t = a + ZW'(65536);
		return t[ZW-1:17];
	endfunction

	logic signed [ZW-18:0] rr, ry, rp;
	assign rr = rnd(zr);
	assign ry = rnd(zy);
	assign rp = rnd(zp);

	always_ff @(posedge clk) begin
		if (enable) begin
			res_q.roll_angle <= (rr > 17'(PI_Q13)) ? PI_Q13 :
				(rr < -17'(PI_Q13)) ? -PI_Q13 : rr[15:0];
			res_q.yaw_angle <= (ry > 17'(PI_Q13)) ? PI_Q13 :
				(ry < -17'(PI_Q13)) ? -PI_Q13 : ry[15:0];
			if (clamp_d[LAT-2]) begin
				res_q.pitch_angle <= sign_d[LAT-2] ? HALF_PI_Q13 : -HALF_PI_Q13;
			end else begin
				res_q.pitch_angle <= (rp > 17'(HALF_PI_Q13)) ? HALF_PI_Q13 :
					(rp < -17'(HALF_PI_Q13)) ? -HALF_PI_Q13 : rp[14:0];
			end
			res_q.gimbal_clamp <= clamp_d[LAT-2];
		end
	end

	assign out_valid = v_d[LAT-1];
	assign out_data = res_q;

`ifndef SYNTHESIS
	a_clamp_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.gimbal_clamp |->
		(out_data.pitch_angle == HALF_PI_Q13 || out_data.pitch_angle == -HALF_PI_Q13))
		else $error("clamped pitch not at pi/2");
	a_roll_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.roll_angle <= PI_Q13 && out_data.roll_angle >= -PI_Q13))
		else $error("roll out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!enable |=> $stable(out_valid))
		else $error("pipe moved while frozen");
`endif
endmodule

>>> sv/quaternion_to_euler_core.sv
`timescale 1ns / 1ps
// quaternion to euler angles, fully pipelined
// quat_in: one quaternion word (w, x, y, z, Q2.14) per valid/ready handshake
// euler_out: one word of pitch (Q2.13 radians), yaw and roll (Q3.13 radians) and gimbal_clamp
// throughput: one word per cycle while the receiver takes each result; the
// three cordic pipelines and the staged square root each take a new operand
// every cycle that the back is not frozen
// stages: 2 front stages, the queue, SQ_STAGES (8) root stages, 17 cordic
// stages and one rounding stage
// the front multiplies and classifies pitch saturation, a small queue feeds
// the back, which freezes whole while its output register holds a word that
// the receiver has not taken; the queue then absorbs the front's words, and
// quat_in.ready drops only once the queue cannot hold what is in flight
// reset clears all valid bits and the queue; no state outlives an item
module quaternion_to_euler_core (
	input logic clk,
	input logic arst_n,
	qte_stream_if.sink quat_in,
	qte_stream_if.source euler_out
);
	import qte_pkg::*;

	logic f_valid;
	front_t f_data;
	front_t q_mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q, rp_q;
	logic [QUEUE_AW:0] cnt_q, cnt_d;
	logic [QUEUE_AW:0] inflight;
	logic push, pop, b_en, b_valid;
	euler_t b_data;

	// quat_in.ready drops only when the queue may overflow from the front's two stages
	assign inflight = cnt_q + (QUEUE_AW+1)'(3);
	assign quat_in.ready = (cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH - 3));

	qte_front u_front (.clk, .arst_n, .in_valid(quat_in.valid && quat_in.ready),
		.in_data(quat_in.data), .enable(1'b1), .out_valid(f_valid), .out_data(f_data));

	// back advances unless its result is held
	assign b_en = !(b_valid && !euler_out.ready);
	assign push = f_valid;
	assign pop = b_en && (cnt_q != 0);
	assign cnt_d = cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);

	always_ff @(posedge clk) begin
		if (push) q_mem[wp_q] <= f_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_d;
		end
	end

	qte_back u_back (.clk, .arst_n, .in_valid(pop), .in_data(q_mem[rp_q]),
		.enable(b_en), .out_valid(b_valid), .out_data(b_data));

	assign euler_out.valid = b_valid;
	assign euler_out.data = b_data;

`ifndef SYNTHESIS
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue overflow");
	a_no_udf: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 0)
		else $error("queue underflow");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight > cnt_q)
		else $error("in-flight count wrapped");
`endif
endmodule
